/* design/cts_pkg.sv */
// Shared types and constants for the CPU task scheduler.
// Used by cts_mod_unit, cts_mem and cpu_task_scheduler_core.
package cts_pkg;

  localparam int MAX_TASKS_DEF = 16;
  localparam int TW = 16;   // time, burst, remaining width
  localparam int PW = 8;    // priority width
  localparam int QW = 8;    // quantum width

  localparam logic [2:0] POL_FCFS = 3'd0;
  localparam logic [2:0] POL_SJF  = 3'd1;
  localparam logic [2:0] POL_RR   = 3'd2;
  localparam logic [2:0] POL_SRTF = 3'd3;
  localparam logic [2:0] POL_PRIO = 3'd4;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic CFG_POLICY  = 1'b0;
  localparam logic CFG_QUANTUM = 1'b1;

  typedef struct packed {
    logic [TW-1:0] burst;
    logic [PW-1:0] prio;
    logic [TW-1:0] arrival;
    logic [TW-1:0] remaining;
  } entry_t;

  typedef struct packed {
    logic          done;
    logic [QW-1:0] rem;
  } mod_stat_t;

endpackage

/* design/cts_mod_unit.sv */
// Bit-serial remainder unit: one dividend bit per cycle.
// Depends on cts_pkg.
module cts_mod_unit (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [cts_pkg::TW-1:0] dividend,
  input  logic [cts_pkg::QW-1:0] divisor,
  output cts_pkg::mod_stat_t     stat
);
  import cts_pkg::*;

  logic [TW-1:0] shreg;
  logic [QW:0]   rem;
  logic [QW:0]   trial;
  logic [3:0]    cnt;
  logic          busy;
  logic          done;

  assign trial = {rem[QW-1:0], shreg[TW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 4'd1;
      if (cnt == 4'd15) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      rem   <= '0;
    end else if (busy) begin
      shreg <= {shreg[TW-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem <= trial - {1'b0, divisor};
      end else begin
        rem <= trial;
      end
    end
  end

  assign stat.done = done;
  assign stat.rem  = rem[QW-1:0];

endmodule

/* design/cts_mem.sv */
// Task table: one synchronous memory, registered read, with per-slot valid
// bits so that unwritten slots read as zero remaining work. Depends on cts_pkg.
module cts_mem #(
  parameter int MAX_TASKS = cts_pkg::MAX_TASKS_DEF,
  parameter int SW        = $clog2(MAX_TASKS)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            we,
  input  logic [SW-1:0]   waddr,
  input  cts_pkg::entry_t wdata,
  input  logic [SW-1:0]   raddr,
  output cts_pkg::entry_t rdata
);
  import cts_pkg::*;

  entry_t                mem [MAX_TASKS];
  logic [MAX_TASKS-1:0]  valid;
  entry_t                data_q;
  logic                  vld_q;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    data_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      vld_q <= 1'b0;
    end else begin
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      vld_q <= valid[raddr];
    end
  end

  always_comb begin
    rdata = data_q;
    if (!vld_q) begin
      rdata.remaining = '0;
    end
  end

endmodule

/* design/cpu_task_scheduler_core.sv */
// CPU task scheduler top level: sequencer, scan and decision logic.
// Depends on cts_pkg, cts_mem, cts_mod_unit.
//
//  channel | dir | handshake        | contents
//  s_*     | in  | s_tvalid/tready  | load or tick word (tuser = opcode)
//  m_*     | out | m_tvalid/tready  | one result word per input word
//  cfg_*   | in  | cfg_we           | policy (index 0), quantum (index 1)
//
// A load passes through the load state. During a tick the scan reads one slot
// per cycle from the task memory while the quantum remainder unit runs in
// parallel. Reset is synchronous and clears the valid bits at once, so no
// clearing pass is needed. A stalled result holds the sequencer in its final
// state; a new word is taken only when idle.
module cpu_task_scheduler_core #(
  parameter int MAX_TASKS = cts_pkg::MAX_TASKS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [3:0] entry_index, [19:4] entry_burst, [27:20] entry_priority,
  // [43:28] entry_arrival, [59:44] tick_time, [63:60] zero
  input  logic [63:0] s_tdata,
  // [0] opcode
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] ran_valid, [4:1] ran_id, [20:5] remaining_after, [21] finished,
  // [37:22] turnaround, [53:38] wait_time, [55:54] zero
  output logic [55:0] m_tdata,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);
  import cts_pkg::*;

  localparam int SW = $clog2(MAX_TASKS);
  localparam int CW = SW + 1;
  localparam logic [SW-1:0] LAST = SW'(MAX_TASKS - 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_DEC  = 3'd3;

  logic [2:0]    state;
  logic [2:0]    policy;
  logic [QW-1:0] quantum;
  logic          locked;
  logic [SW-1:0] cur;
  logic          rr_first;

  logic [TW-1:0] t;
  logic [SW-1:0] start;
  logic [CW-1:0] cnt;
  logic          rd_pend;
  logic [SW-1:0] rd_slot;

  logic          first_f, wrap_f, min_f;
  logic [SW-1:0] first_k, wrap_k, min_k;
  entry_t        first_e, wrap_e, min_e, cur_e;
  logic [TW-1:0] min_key;

  logic          mem_we;
  logic [SW-1:0] mem_waddr;
  entry_t        mem_wdata;
  entry_t        rdata;
  mod_stat_t     mstat;

  logic          accept;
  logic          out_free;
  logic [3:0]    in_idx;
  logic [TW-1:0] in_tick;
  logic          ld_ok;
  logic [SW-1:0] cur_inc;
  logic [QW-1:0] qdiv;

  assign in_idx   = s_tdata[3:0];
  assign in_tick  = s_tdata[59:44];
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign ld_ok    = (32'(in_idx) < MAX_TASKS);
  assign cur_inc  = (cur == LAST) ? '0 : cur + 1'b1;
  assign qdiv     = (quantum == '0) ? QW'(1) : quantum;

  cts_mem #(.MAX_TASKS(MAX_TASKS), .SW(SW)) u_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (cnt[SW-1:0]),
    .rdata (rdata)
  );

  cts_mod_unit u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (accept && s_tuser == OP_TICK),
    .dividend (in_tick - 16'd1),
    .divisor  (qdiv),
    .stat     (mstat)
  );

  // Configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      policy  <= POL_FCFS;
      quantum <= QW'(2);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_POLICY:  policy  <= cfg_data[2:0];
        CFG_QUANTUM: quantum <= cfg_data;
        default:     ;
      endcase
    end
  end

  // Scan evaluation of the word read in the previous cycle
  logic          ev_ready;
  logic [TW-1:0] ev_key;
  assign ev_ready = (t > rdata.arrival) && (rdata.remaining != '0);
  assign ev_key   = (policy == POL_PRIO) ? TW'(rdata.prio) : rdata.remaining;

  always_ff @(posedge clk) begin
    if (accept) begin
      first_f <= 1'b0;
      wrap_f  <= 1'b0;
      min_f   <= 1'b0;
      t       <= in_tick;
      start   <= rr_first ? '0 : cur_inc;
    end else if (state == ST_SCAN && rd_pend) begin
      if (ev_ready && !first_f) begin
        first_f <= 1'b1;
        first_k <= rd_slot;
        first_e <= rdata;
      end
      if (ev_ready && !wrap_f && rd_slot >= start) begin
        wrap_f <= 1'b1;
        wrap_k <= rd_slot;
        wrap_e <= rdata;
      end
      if (ev_ready && (!min_f || ev_key < min_key)) begin
        min_f   <= 1'b1;
        min_k   <= rd_slot;
        min_e   <= rdata;
        min_key <= ev_key;
      end
      if (rd_slot == cur) begin
        cur_e <= rdata;
      end
    end
  end

  // Decision
  logic          run;
  logic [SW-1:0] tgt_k;
  entry_t        tgt_e;
  logic          locked_next;
  logic [SW-1:0] cur_next;
  logic          rr_first_next;
  logic          sched;
  logic          lock_eff;
  logic          tgt_ready;
  logic [TW-1:0] rem_after;
  logic          fin;
  logic [TW-1:0] ta;
  logic [TW-1:0] wt;

  always_comb begin
    run           = 1'b0;
    tgt_k         = cur;
    tgt_e         = cur_e;
    locked_next   = locked;
    cur_next      = cur;
    rr_first_next = rr_first;
    lock_eff      = 1'b0;
    sched         = (t != '0) && (mstat.rem == '0);
    case (policy)
      POL_FCFS: begin
        run   = first_f;
        tgt_k = first_k;
        tgt_e = first_e;
      end
      POL_SRTF: begin
        run   = min_f;
        tgt_k = min_k;
        tgt_e = min_e;
      end
      POL_SJF, POL_PRIO: begin
        if (!locked && min_f) begin
          tgt_k    = min_k;
          tgt_e    = min_e;
          cur_next = min_k;
        end
        lock_eff = locked || min_f;
      end
      POL_RR: begin
        if (sched) begin
          rr_first_next = 1'b0;
          if (wrap_f) begin
            run = 1'b1; tgt_k = wrap_k; tgt_e = wrap_e; cur_next = wrap_k;
          end else if (first_f) begin
            run = 1'b1; tgt_k = first_k; tgt_e = first_e; cur_next = first_k;
          end else begin
            cur_next = (start == '0) ? LAST : start - 1'b1;
          end
        end
      end
      default: ;
    endcase
    tgt_ready = (t > tgt_e.arrival) && (tgt_e.remaining != '0);
    if (policy == POL_RR && !sched) begin
      run = tgt_ready;
    end
    if (lock_eff) begin
      run = (policy == POL_SJF) ? tgt_ready : (tgt_e.remaining != '0);
    end
    run       = run && (tgt_e.remaining != '0);
    rem_after = run ? tgt_e.remaining - 1'b1 : tgt_e.remaining;
    if (lock_eff) begin
      locked_next = (rem_after != '0);
    end
    fin = run && (rem_after == '0);
    ta  = (t > tgt_e.arrival) ? t - tgt_e.arrival : '0;
    wt  = (ta > tgt_e.burst) ? ta - tgt_e.burst : '0;
  end

  logic dec_go;
  assign dec_go = (state == ST_DEC) && mstat.done && out_free;

  // Memory write: loads in idle, write-back at decision; scan reads never
  // overlap either, so no forwarding is needed.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = tgt_k;
    mem_wdata = tgt_e;
    mem_wdata.remaining = rem_after;
    if (accept && s_tuser == OP_LOAD) begin
      mem_we    = ld_ok;
      mem_waddr = SW'(in_idx);
      mem_wdata.burst     = s_tdata[19:4];
      mem_wdata.prio      = s_tdata[27:20];
      mem_wdata.arrival   = s_tdata[43:28];
      mem_wdata.remaining = s_tdata[19:4];
    end else if (dec_go) begin
      mem_we = run;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      rd_pend  <= 1'b0;
      locked   <= 1'b0;
      cur      <= '0;
      rr_first <= 1'b1;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            cnt     <= '0;
            rd_pend <= 1'b0;
            state   <= (s_tuser == OP_TICK) ? ST_SCAN : ST_LOAD;
          end
        end
        ST_LOAD: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          rd_pend <= (cnt != CW'(MAX_TASKS));
          rd_slot <= cnt[SW-1:0];
          if (cnt == CW'(MAX_TASKS)) begin
            state <= ST_DEC;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_DEC: begin
          if (dec_go) begin
            locked   <= locked_next;
            cur      <= cur_next;
            rr_first <= rr_first_next;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_LOAD && out_free) begin
      m_tvalid <= 1'b1;
    end else if (dec_go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_LOAD && out_free) begin
      m_tdata <= '0;
    end else if (dec_go) begin
      m_tdata <= {2'b00,
                  fin ? wt : 16'd0,
                  fin ? ta : 16'd0,
                  fin,
                  run ? rem_after : 16'd0,
                  run ? 4'(tgt_k) : 4'd0,
                  run};
    end
  end

  a_fin_ran: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[21] |-> m_tdata[0])
    else $error("finished result without a run");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> !mem_we)
    else $error("task memory written during scan");

  a_lock_policy: assert property (@(posedge clk) disable iff (rst)
    $rose(locked) |-> $past(policy) == POL_SJF || $past(policy) == POL_PRIO)
    else $error("lock taken under a non-locking policy");

endmodule
